// ----- rtl/hsvc_pkg.sv -----
// hsvc_pkg: shared types and constants for the HSV to RGB converter.
// Used by hsvc_prep, hsvc_arith and hsv_to_rgb_converter; no dependencies.

package hsvc_pkg;

   // Field width of every channel on the ports
   localparam int FIELD_W = 13;

   // Default number of fraction bits (4096 means 1.0)
   localparam int FRACTION_BITS_DEFAULT = 12;

   // Hue geometry in 1/16 degree units
   localparam logic [12:0] HUE_SECTOR = 13'd960;
   localparam logic [12:0] HUE_DOUBLE = 13'd1920;
   localparam logic [12:0] HUE_TURN   = 13'd5760;

   // Sector weight 960 - |(hue mod 1920) - 960| spans 0..960
   localparam int WEIGHT_W = 10;

   // Divide by 960 as (n >> 6) / 15; the /15 is a reciprocal multiply,
   // exact for every 17-bit n
   localparam int          DIV_PRE_SHIFT = 6;
   localparam int          QUOT_IN_W     = 17;
   localparam int          RECIP_W       = 18;
   localparam logic [17:0] RECIP_15      = 18'd139811;
   localparam int          RECIP_SHIFT   = 21;

   localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

   // 60-degree sector of the hue
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

   // Front stage result: clamped inputs, sector and hue weight
   typedef struct packed {
      logic [FIELD_W-1:0]  saturation;
      logic [FIELD_W-1:0]  brightness;
      logic [WEIGHT_W-1:0] weight;
      sector_type          sector;
   } prep_type;

   // Arithmetic result: chroma, secondary component and offset
   typedef struct packed {
      logic [FIELD_W-1:0] chroma;
      logic [FIELD_W-1:0] second;
      logic [FIELD_W-1:0] offset;
      sector_type         sector;
   } mix_type;

endpackage

// ----- rtl/hsvc_prep.sv -----
// hsvc_prep: first pipeline stage; clamps saturation and value, wraps hue,
// finds its sector and the sector weight. Depends on hsvc_pkg.

module hsvc_prep #(
   parameter int FRACTION_BITS = hsvc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic [hsvc_pkg::FIELD_W-1:0]  hue,
   input  logic [hsvc_pkg::FIELD_W-1:0]  saturation,
   input  logic [hsvc_pkg::FIELD_W-1:0]  brightness,
   output logic                          out_valid,
   output hsvc_pkg::prep_type            out_data
);

   localparam logic [17:0] ONE = 18'd1 << FRACTION_BITS;

   logic                         valid_ff;
   hsvc_pkg::prep_type           data_ff;
   hsvc_pkg::prep_type           data_in;
   logic [hsvc_pkg::FIELD_W-1:0] hue_wrap;
   logic [hsvc_pkg::FIELD_W-1:0] hue_rem;

   // Clamp, wrap and split the hue into sector and weight
   always_comb begin
      data_in.saturation = saturation;
      data_in.brightness = brightness;
      if ({5'd0, saturation} > ONE) begin
         data_in.saturation = ONE[hsvc_pkg::FIELD_W-1:0];
      end
      if ({5'd0, brightness} > ONE) begin
         data_in.brightness = ONE[hsvc_pkg::FIELD_W-1:0];
      end

      hue_wrap = hue;
      if (hue >= hsvc_pkg::HUE_TURN) begin
         hue_wrap = hue - hsvc_pkg::HUE_TURN;
      end

      if (hue_wrap >= 13'd4800) begin
         data_in.sector = hsvc_pkg::SECTOR_MAGENTA_RED;
      end else if (hue_wrap >= 13'd3840) begin
         data_in.sector = hsvc_pkg::SECTOR_BLUE_MAGENTA;
      end else if (hue_wrap >= 13'd2880) begin
         data_in.sector = hsvc_pkg::SECTOR_CYAN_BLUE;
      end else if (hue_wrap >= hsvc_pkg::HUE_DOUBLE) begin
         data_in.sector = hsvc_pkg::SECTOR_GREEN_CYAN;
      end else if (hue_wrap >= hsvc_pkg::HUE_SECTOR) begin
         data_in.sector = hsvc_pkg::SECTOR_YELLOW_GREEN;
      end else begin
         data_in.sector = hsvc_pkg::SECTOR_RED_YELLOW;
      end

      // hue mod 1920
      if (hue_wrap >= 13'd3840) begin
         hue_rem = hue_wrap - 13'd3840;
      end else if (hue_wrap >= hsvc_pkg::HUE_DOUBLE) begin
         hue_rem = hue_wrap - hsvc_pkg::HUE_DOUBLE;
      end else begin
         hue_rem = hue_wrap;
      end

      // weight = 960 - |rem - 960|
      if (hue_rem >= hsvc_pkg::HUE_SECTOR) begin
         data_in.weight = 10'(hsvc_pkg::HUE_DOUBLE - hue_rem);
      end else begin
         data_in.weight = hue_rem[hsvc_pkg::WEIGHT_W-1:0];
      end
   end

   // Advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/hsvc_arith.sv -----
// hsvc_arith: three multiplier stages: chroma S*V, chroma times hue weight,
// and division by 960 through a reciprocal multiply. Depends on hsvc_pkg.

module hsvc_arith #(
   parameter int FRACTION_BITS = hsvc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  hsvc_pkg::prep_type in_data,
   output logic               out_valid,
   output hsvc_pkg::mix_type  out_data
);

   localparam int FW = hsvc_pkg::FIELD_W;
   localparam int PW = FW + hsvc_pkg::WEIGHT_W;
   localparam int QW = hsvc_pkg::QUOT_IN_W + hsvc_pkg::RECIP_W;

   // Stage A: chroma
   logic                valid_a_ff;
   logic [FW-1:0]       chroma_a_ff;
   logic [FW-1:0]       bright_a_ff;
   logic [hsvc_pkg::WEIGHT_W-1:0] weight_a_ff;
   hsvc_pkg::sector_type sector_a_ff;
   logic [2*FW-1:0]     sv_prod;
   logic [2*FW-1:0]     sv_shift;

   // Stage B: chroma times weight, pre-shifted
   logic                valid_b_ff;
   logic [hsvc_pkg::QUOT_IN_W-1:0] numer_b_ff;
   logic [FW-1:0]       chroma_b_ff;
   logic [FW-1:0]       offset_b_ff;
   hsvc_pkg::sector_type sector_b_ff;
   logic [PW-1:0]       cw_prod;

   // Stage C: quotient
   logic                valid_c_ff;
   hsvc_pkg::mix_type   data_c_ff;
   hsvc_pkg::mix_type   data_c_in;
   logic [QW-1:0]       recip_prod;

   always_comb begin
      sv_prod  = in_data.saturation * in_data.brightness;
      sv_shift = sv_prod >> FRACTION_BITS;
      cw_prod  = chroma_a_ff * weight_a_ff;
      recip_prod = numer_b_ff * hsvc_pkg::RECIP_15;

      data_c_in.chroma = chroma_b_ff;
      data_c_in.offset = offset_b_ff;
      data_c_in.sector = sector_b_ff;
      data_c_in.second = recip_prod[hsvc_pkg::RECIP_SHIFT +: FW];
   end

   // Hold valid bits under reset, advance on enable
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      if (enable) begin
         chroma_a_ff <= sv_shift[FW-1:0];
         bright_a_ff <= in_data.brightness;
         weight_a_ff <= in_data.weight;
         sector_a_ff <= in_data.sector;

         numer_b_ff  <= cw_prod[hsvc_pkg::DIV_PRE_SHIFT +: hsvc_pkg::QUOT_IN_W];
         chroma_b_ff <= chroma_a_ff;
         offset_b_ff <= bright_a_ff - chroma_a_ff;
         sector_b_ff <= sector_a_ff;

         data_c_ff   <= data_c_in;
      end
   end

   assign out_valid = valid_c_ff;
   assign out_data  = data_c_ff;

endmodule

// ----- rtl/hsv_to_rgb_converter.sv -----
// hsv_to_rgb_converter: top level of the HSV to RGB pipeline.
// Instantiates hsvc_prep and hsvc_arith; depends on hsvc_pkg.

// The converter takes one HSV transaction per clock while req_stall is low
// and returns one RGB transaction through a clamp and sector decode stage, three
// multiplier stages (S*V, chroma times hue weight, reciprocal divide by 960)
// and the channel mix with its output register. All stages move together;
// req_stall rises only while a finished transaction sits in the output
// register and rsp_stall is high, so a new transaction enters on every
// cycle the output is taken. Hue 5760 and above wraps by a full turn, and
// saturation or value above 1.0 is clamped to 1.0.

module hsv_to_rgb_converter #(
   parameter int FRACTION_BITS = hsvc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [hsvc_pkg::FIELD_W-1:0] req_hue,
   input  logic [hsvc_pkg::FIELD_W-1:0] req_saturation,
   input  logic [hsvc_pkg::FIELD_W-1:0] req_brightness,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hsvc_pkg::FIELD_W-1:0] rsp_red,
   output logic [hsvc_pkg::FIELD_W-1:0] rsp_green,
   output logic [hsvc_pkg::FIELD_W-1:0] rsp_blue
);

   localparam int FW = hsvc_pkg::FIELD_W;

   logic               enable;
   logic               prep_valid;
   hsvc_pkg::prep_type prep_data;
   logic               mix_valid;
   hsvc_pkg::mix_type  mix_data;

   logic               rsp_valid_ff;
   logic [FW-1:0]      red_ff;
   logic [FW-1:0]      green_ff;
   logic [FW-1:0]      blue_ff;
   logic [FW-1:0]      red_in;
   logic [FW-1:0]      green_in;
   logic [FW-1:0]      blue_in;
   logic [FW-1:0]      red_pick;
   logic [FW-1:0]      green_pick;
   logic [FW-1:0]      blue_pick;
   logic [FW:0]        red_sum;
   logic [FW:0]        green_sum;
   logic [FW:0]        blue_sum;

   // Advance the whole pipeline unless the output is held
   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   hsvc_prep #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .hue       (req_hue),
      .saturation(req_saturation),
      .brightness(req_brightness),
      .out_valid (prep_valid),
      .out_data  (prep_data)
   );

   hsvc_arith #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_arith (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (prep_valid),
      .in_data  (prep_data),
      .out_valid(mix_valid),
      .out_data (mix_data)
   );

   // Place chroma and secondary on the channels by sector, add the offset
   always_comb begin
      case (mix_data.sector)
         hsvc_pkg::SECTOR_RED_YELLOW: begin
            red_pick = mix_data.chroma; green_pick = mix_data.second; blue_pick = '0;
         end
         hsvc_pkg::SECTOR_YELLOW_GREEN: begin
            red_pick = mix_data.second; green_pick = mix_data.chroma; blue_pick = '0;
         end
         hsvc_pkg::SECTOR_GREEN_CYAN: begin
            red_pick = '0; green_pick = mix_data.chroma; blue_pick = mix_data.second;
         end
         hsvc_pkg::SECTOR_CYAN_BLUE: begin
            red_pick = '0; green_pick = mix_data.second; blue_pick = mix_data.chroma;
         end
         hsvc_pkg::SECTOR_BLUE_MAGENTA: begin
            red_pick = mix_data.second; green_pick = '0; blue_pick = mix_data.chroma;
         end
         default: begin
            red_pick = mix_data.chroma; green_pick = '0; blue_pick = mix_data.second;
         end
      endcase

      red_sum   = {1'b0, red_pick}   + {1'b0, mix_data.offset};
      green_sum = {1'b0, green_pick} + {1'b0, mix_data.offset};
      blue_sum  = {1'b0, blue_pick}  + {1'b0, mix_data.offset};

      // Saturate at the field maximum
      red_in   = red_sum[FW]   ? hsvc_pkg::FIELD_MAX : red_sum[FW-1:0];
      green_in = green_sum[FW] ? hsvc_pkg::FIELD_MAX : green_sum[FW-1:0];
      blue_in  = blue_sum[FW]  ? hsvc_pkg::FIELD_MAX : blue_sum[FW-1:0];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= mix_valid;
      end
      if (enable) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule
